// ===== src/mi3_pkg.sv =====
// Shared types and constants for the 3x3 fixed-point matrix inverse.
// No dependencies; every other file in this block imports it.
package mi3_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int EL_W          = 32;               // element width
    localparam int MAG_W         = 64;               // cofactor magnitude, at most 2^63
    localparam int DMAG_W        = MAG_W + EL_W;     // determinant magnitude, below 2^96
    localparam int DET_W         = DMAG_W + 2;       // signed sum of three terms
    localparam int Q_W           = 33;               // quotient bits resolved per lane
    localparam int NUM_CF        = 9;
    localparam int DET_LAT       = 7;

    localparam logic [EL_W-1:0] SAT_POS = 32'h7FFF_FFFF;
    localparam logic [EL_W-1:0] SAT_NEG = 32'h8000_0000;

    typedef logic signed [EL_W-1:0] t_el;

    typedef struct packed {
        t_el a00; t_el a01; t_el a02;
        t_el a10; t_el a11; t_el a12;
        t_el a20; t_el a21; t_el a22;
    } t_mat;

    typedef struct packed {
        t_el  r00; t_el r01; t_el r02;
        t_el  r10; t_el r11; t_el r12;
        t_el  r20; t_el r21; t_el r22;
        logic singular;
        logic clipped;
    } t_inv;

    // determinant magnitude travelling alongside the divider stages
    typedef struct packed {
        logic              zero;
        logic [DMAG_W-1:0] dmag;
    } t_dstage;

    // what one lane hands to the merging stage
    typedef struct packed {
        logic [Q_W-1:0] q;
        logic           ovf;
        logic           neg;
    } t_lane;

    // cofactor i = a[p]*a[q] - a[r]*a[s], in adjugate order
    localparam int unsigned CF_OPS [NUM_CF][4] = '{
        '{4, 8, 5, 7}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
        '{5, 6, 3, 8}, '{0, 8, 2, 6}, '{2, 3, 0, 5},
        '{3, 7, 4, 6}, '{1, 6, 0, 7}, '{0, 4, 1, 3}
    };

endpackage

// ===== src/mi3_det.sv =====
// Cofactor and determinant pipeline of the 3x3 inverse (seven stages).
// Depends on mi3_pkg.
module mi3_det (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  mi3_pkg::t_mat               i_mat,
    output logic [mi3_pkg::MAG_W-1:0]   o_cmag [mi3_pkg::NUM_CF],
    output logic [mi3_pkg::NUM_CF-1:0]  o_cneg,
    output logic [mi3_pkg::DMAG_W-1:0]  o_dmag,
    output logic                        o_dneg,
    output logic                        o_dzero
);
    import mi3_pkg::*;

    t_el a [NUM_CF];
    assign a[0] = i_mat.a00;
    assign a[1] = i_mat.a01;
    assign a[2] = i_mat.a02;
    assign a[3] = i_mat.a10;
    assign a[4] = i_mat.a11;
    assign a[5] = i_mat.a12;
    assign a[6] = i_mat.a20;
    assign a[7] = i_mat.a21;
    assign a[8] = i_mat.a22;

    logic signed [2*EL_W-1:0] r_pa [NUM_CF];
    logic signed [2*EL_W-1:0] r_pb [NUM_CF];
    t_el                      r_top1 [3];
    logic signed [2*EL_W:0]   r_c [NUM_CF];
    t_el                      r_top2 [3];
    logic [MAG_W-1:0]         r_cm [5][NUM_CF];
    logic [NUM_CF-1:0]        r_cn [5];
    logic [EL_W-1:0]          r_amag [3];
    logic [2:0]               r_aneg;
    logic [2*EL_W-1:0]        r_pl [3];
    logic [2*EL_W-1:0]        r_ph [3];
    logic [2:0]               r_tneg4;
    logic [DMAG_W-1:0]        r_tmag [3];
    logic [2:0]               r_tneg5;
    logic signed [DET_W-1:0]  r_det;
    logic [DMAG_W-1:0]        r_dmag;
    logic                     r_dneg;
    logic                     r_dzero;

    logic [2*EL_W:0]   c_neg [NUM_CF];
    logic [DET_W-1:0]  t_x [3];
    logic [DET_W-1:0]  det_neg;

    always_comb begin
        for (int i = 0; i < NUM_CF; i++) begin
            c_neg[i] = (2*EL_W+1)'(0) - r_c[i];
        end
        for (int k = 0; k < 3; k++) begin
            t_x[k] = {2'b00, r_tmag[k]} ^ {DET_W{r_tneg5[k]}};
        end
        det_neg = DET_W'(0) - r_det;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // products of 2x2 minors
            for (int i = 0; i < NUM_CF; i++) begin
                r_pa[i] <= a[CF_OPS[i][0]] * a[CF_OPS[i][1]];
                r_pb[i] <= a[CF_OPS[i][2]] * a[CF_OPS[i][3]];
            end
            for (int k = 0; k < 3; k++) begin
                r_top1[k] <= a[k];
                r_top2[k] <= r_top1[k];
            end
            // cofactors, exact
            for (int i = 0; i < NUM_CF; i++) begin
                r_c[i] <= {r_pa[i][2*EL_W-1], r_pa[i]} - {r_pb[i][2*EL_W-1], r_pb[i]};
            end
            // sign and magnitude
            for (int i = 0; i < NUM_CF; i++) begin
                r_cn[0][i] <= r_c[i][2*EL_W];
                r_cm[0][i] <= r_c[i][2*EL_W] ? c_neg[i][MAG_W-1:0] : r_c[i][MAG_W-1:0];
            end
            for (int k = 0; k < 3; k++) begin
                r_aneg[k] <= r_top2[k][EL_W-1];
                r_amag[k] <= r_top2[k][EL_W-1] ? EL_W'(0) - r_top2[k] : r_top2[k];
            end
            // first-row terms as two 32x32 partial products each
            for (int k = 0; k < 3; k++) begin
                r_pl[k]    <= r_amag[k] * r_cm[0][3*k][EL_W-1:0];
                r_ph[k]    <= r_amag[k] * r_cm[0][3*k][MAG_W-1:EL_W];
                r_tneg4[k] <= r_aneg[k] ^ r_cn[0][3*k];
            end
            for (int k = 0; k < 3; k++) begin
                r_tmag[k]  <= {r_ph[k], {EL_W{1'b0}}} + {{EL_W{1'b0}}, r_pl[k]};
                r_tneg5[k] <= r_tneg4[k];
            end
            // signed sum: invert and add one for each negative term
            r_det <= t_x[0] + t_x[1] + t_x[2] + DET_W'(r_tneg5[0])
                   + DET_W'(r_tneg5[1]) + DET_W'(r_tneg5[2]);
            r_dneg  <= r_det[DET_W-1];
            r_dmag  <= r_det[DET_W-1] ? det_neg[DMAG_W-1:0] : r_det[DMAG_W-1:0];
            r_dzero <= (r_det == '0);
            // hold cofactors level with the determinant
            for (int s = 1; s < 5; s++) begin
                r_cm[s] <= r_cm[s-1];
                r_cn[s] <= r_cn[s-1];
            end
        end
    end

    assign o_cmag  = r_cm[4];
    assign o_cneg  = r_cn[4];
    assign o_dmag  = r_dmag;
    assign o_dneg  = r_dneg;
    assign o_dzero = r_dzero;

endmodule

// ===== src/mi3_lane.sv =====
// One divider lane: cofactor magnitude << 2*FRAC_BITS over the determinant,
// an overflow check then one restoring step per stage. Depends on mi3_pkg.
module mi3_lane #(
    parameter int FRAC_BITS = mi3_pkg::FRAC_BITS_DEF
) (
    input  logic                                            i_clk,
    input  logic                                            i_en,
    input  logic [mi3_pkg::MAG_W-1:0]                       i_cmag,
    input  logic                                            i_cneg,
    input  logic [mi3_pkg::DMAG_W-1:0]                      i_dmag,
    input  logic                                            i_dneg,
    input  mi3_pkg::t_dstage [mi3_pkg::Q_W-1:0]             i_dline,
    output mi3_pkg::t_lane                                  o_res
);
    import mi3_pkg::*;

    localparam int NUM_W = MAG_W + 2*FRAC_BITS;
    localparam int HI_W  = NUM_W - Q_W;
    localparam int CMP_W = (HI_W > DMAG_W) ? HI_W : DMAG_W;

    logic [NUM_W-1:0] num;
    logic [HI_W-1:0]  hi;

    assign num = {i_cmag, {(2*FRAC_BITS){1'b0}}};
    assign hi  = num[NUM_W-1:Q_W];

    logic [DMAG_W-1:0] r_rem [Q_W+1];
    logic [Q_W-1:0]    r_lo  [Q_W+1];
    logic [Q_W-1:0]    r_q   [Q_W+1];
    logic [Q_W:0]      r_ovf;
    logic [Q_W:0]      r_neg;

    // quotient of 2^Q_W or more cannot fit: flag it before dividing
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= DMAG_W'(hi);
            r_lo[0]  <= num[Q_W-1:0];
            r_q[0]   <= '0;
            r_ovf[0] <= CMP_W'(hi) >= CMP_W'(i_dmag);
            r_neg[0] <= i_cneg ^ i_dneg;
        end
    end

    for (genvar k = 0; k < Q_W; k++) begin : g_step
        logic [DMAG_W:0] trial;
        logic [DMAG_W:0] diff;
        logic            ge;

        always_comb begin
            trial = {r_rem[k], r_lo[k][Q_W-1]};
            diff  = trial - {1'b0, i_dline[k].dmag};
            ge    = trial >= {1'b0, i_dline[k].dmag};
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k+1] <= ge ? diff[DMAG_W-1:0] : trial[DMAG_W-1:0];
                r_lo[k+1]  <= r_lo[k] << 1;
                r_q[k+1]   <= {r_q[k][Q_W-2:0], ge};
                r_ovf[k+1] <= r_ovf[k];
                r_neg[k+1] <= r_neg[k];
            end
        end
    end

    assign o_res.q   = r_q[Q_W];
    assign o_res.ovf = r_ovf[Q_W];
    assign o_res.neg = r_neg[Q_W];

endmodule

// ===== src/mi3_merge.sv =====
// Merging stage: signs, saturates and gathers the nine lane quotients into
// the output register with the singular and clipped flags. Depends on mi3_pkg.
module mi3_merge (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  mi3_pkg::t_lane       i_lane [mi3_pkg::NUM_CF],
    input  logic                 i_zero,
    output mi3_pkg::t_inv        o_res
);
    import mi3_pkg::*;

    logic [EL_W-1:0]   v [NUM_CF];
    logic [NUM_CF-1:0] clip;
    logic [Q_W-1:0]    lim [NUM_CF];
    t_inv              r_res;

    always_comb begin
        for (int i = 0; i < NUM_CF; i++) begin
            lim[i]  = i_lane[i].neg ? Q_W'(SAT_NEG) : Q_W'(SAT_POS);
            clip[i] = i_lane[i].ovf || (i_lane[i].q > lim[i]);
            if (i_zero) begin
                v[i] = '0;
            end else if (clip[i]) begin
                v[i] = i_lane[i].neg ? SAT_NEG : SAT_POS;
            end else if (i_lane[i].neg) begin
                v[i] = EL_W'(0) - i_lane[i].q[EL_W-1:0];
            end else begin
                v[i] = i_lane[i].q[EL_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res.r00      <= v[0];
            r_res.r01      <= v[1];
            r_res.r02      <= v[2];
            r_res.r10      <= v[3];
            r_res.r11      <= v[4];
            r_res.r12      <= v[5];
            r_res.r20      <= v[6];
            r_res.r21      <= v[7];
            r_res.r22      <= v[8];
            r_res.singular <= i_zero;
            r_res.clipped  <= !i_zero && (clip != '0);
        end
    end

    assign o_res = r_res;

endmodule

// ===== src/matrix3x3_inverse.sv =====
// Top level of the 3x3 fixed-point matrix inverse by the adjugate.
// Depends on mi3_pkg, mi3_det, mi3_lane and mi3_merge.
//
//   channel   valid     stall     payload
//   input     i_valid   o_stall   i_mat (t_mat)
//   output    o_valid   i_stall   o_res (t_inv)
//
// One matrix a cycle while no result is held at the output; the depth comes
// mostly from the one-bit-per-stage divider chain in each of the nine lanes.
// All stages advance together; a held result at the output freezes the pipe.
// Reset clears the valid chain only; data registers are not reset.
module matrix3x3_inverse #(
    parameter int FRAC_BITS = mi3_pkg::FRAC_BITS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  mi3_pkg::t_mat   i_mat,
    output logic            o_valid,
    input  logic            i_stall,
    output mi3_pkg::t_inv   o_res
);
    import mi3_pkg::*;

    localparam int TOT = DET_LAT + Q_W + 2;

    logic                en;
    logic [TOT-1:0]      r_vld;
    logic [MAG_W-1:0]    cmag [NUM_CF];
    logic [NUM_CF-1:0]   cneg;
    logic [DMAG_W-1:0]   dmag;
    logic                dneg;
    logic                dzero;
    t_dstage [Q_W:0]     r_dl;
    t_lane               lane [NUM_CF];

    // advance unless a finished transaction is being held
    assign en      = !(r_vld[TOT-1] && i_stall);
    assign o_stall = !en;
    assign o_valid = r_vld[TOT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[TOT-2:0], i_valid};
        end
    end

    // determinant shared by all lanes, one copy per divider stage plus one for the merge
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dl[0].dmag <= dmag;
            r_dl[0].zero <= dzero;
            for (int k = 1; k <= Q_W; k++) begin
                r_dl[k] <= r_dl[k-1];
            end
        end
    end

    mi3_det u_det (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_mat   (i_mat),
        .o_cmag  (cmag),
        .o_cneg  (cneg),
        .o_dmag  (dmag),
        .o_dneg  (dneg),
        .o_dzero (dzero)
    );

    for (genvar g = 0; g < NUM_CF; g++) begin : g_lane
        mi3_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
            .i_clk   (i_clk),
            .i_en    (en),
            .i_cmag  (cmag[g]),
            .i_cneg  (cneg[g]),
            .i_dmag  (dmag),
            .i_dneg  (dneg),
            .i_dline (r_dl[Q_W-1:0]),
            .o_res   (lane[g])
        );
    end

    mi3_merge u_merge (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_lane (lane),
        .i_zero (r_dl[Q_W].zero),
        .o_res  (o_res)
    );

    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("output valid straight after reset");

    a_singular_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_res.singular |-> !o_res.clipped && o_res.r00 == '0
            && o_res.r01 == '0 && o_res.r02 == '0 && o_res.r10 == '0
            && o_res.r11 == '0 && o_res.r12 == '0 && o_res.r20 == '0
            && o_res.r21 == '0 && o_res.r22 == '0)
        else $error("singular result with nonzero content");

    a_hold_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |=> r_vld == $past(r_vld))
        else $error("pipeline moved while held");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> r_vld[0])
        else $error("accepted transaction lost at entry");

endmodule
